/* design/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// Types and constants shared by the attribute table modules.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int ID_W    = 8;
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 48;
  localparam int COUNT_W = 6;

  localparam logic [ID_W-1:0]    TEMP_ID   = 8'd194;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  typedef enum logic [1:0] {
    STATUS_STORED  = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] worst;
    logic [BYTE_W-1:0] threshold;
    logic [RAW_W-1:0]  raw;
  } attr_entry_t;

  typedef struct packed {
    logic match;
    logic free;
    logic fail;
    logic temp;
  } eval_res_t;

endpackage

/* design/sat_if.sv */
// ----------------------------------------------------------------------------
// sat_in_if / sat_out_if
// Valid-ready channels for attribute reports and table results.
// ----------------------------------------------------------------------------
interface sat_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  attr_id;
  logic [7:0]  attr_value;
  logic [7:0]  attr_worst;
  logic [7:0]  attr_threshold;
  logic [47:0] attr_raw;

  modport source (
    output valid, attr_id, attr_value, attr_worst, attr_threshold, attr_raw,
    input  ready
  );
  modport sink (
    input  valid, attr_id, attr_value, attr_worst, attr_threshold, attr_raw,
    output ready
  );
endinterface

interface sat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] failing_count;
  logic       healthy;
  logic       temp_found;
  logic [7:0] temperature;

  modport source (
    output valid, status, failing_count, healthy, temp_found, temperature,
    input  ready
  );
  modport sink (
    input  valid, status, failing_count, healthy, temp_found, temperature,
    output ready
  );
endinterface

/* design/sat_store.sv */
// ----------------------------------------------------------------------------
// sat_store
// Entry memory with one write and one registered read port, plus used bits.
// ----------------------------------------------------------------------------
module sat_store #(
  parameter int ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  output sat_pkg::attr_entry_t rd_entry,
  output logic                rd_used,
  input  logic                wr_en,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
  input  sat_pkg::attr_entry_t wr_entry
);
  import sat_pkg::*;

  attr_entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] used;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_used  <= used[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en) begin
      used[wr_addr] <= 1'b1;
    end
  end

endmodule

/* design/sat_eval.sv */
// ----------------------------------------------------------------------------
// sat_eval
// Shared compare unit: classifies one entry against the pending report.
// ----------------------------------------------------------------------------
module sat_eval (
  input  logic                 scan,
  input  logic                 used,
  input  sat_pkg::attr_entry_t entry,
  input  logic [7:0]           req_id,
  output sat_pkg::eval_res_t   res
);
  import sat_pkg::*;

  logic hit;
  logic live;

  // in scan mode drop the slot about to be overwritten
  assign hit  = used && (entry.id == req_id);
  assign live = used && !(scan && hit);

  assign res.match = scan && hit;
  assign res.free  = !used;
  assign res.fail  = live && (entry.threshold != '0) && (entry.value <= entry.threshold);
  assign res.temp  = live && (entry.id == TEMP_ID);

endmodule

/* design/smart_attribute_table.sv */
// ----------------------------------------------------------------------------
// smart_attribute_table
// Table of disk-health attribute entries with failure and temperature
// summaries, walked one entry a cycle through a shared compare unit.
//
//   channel  dir  payload
//   in_ch    in   attr_id, attr_value, attr_worst, attr_threshold, attr_raw
//   out_ch   out  status, failing_count, healthy, temp_found, temperature
//
// An item is accepted, then the entry memory is read ENTRIES times, the
// last read lands, the scan is left, and the write state stores the entry
// when its id is valid and there is room.
// Reset clears the used bits at once; no clearing pass.
// A result waits in the output register; the next item is accepted meanwhile
// and holds in its write state until that result is taken.
// ----------------------------------------------------------------------------
module smart_attribute_table #(
  parameter int ENTRIES = 32
) (
  input  logic      clk,
  input  logic      rst,
  sat_in_if.sink    in_ch,
  sat_out_if.source out_ch
);
  import sat_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SUM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t      state;
  attr_entry_t req;
  logic [CNT_W-1:0] iss_cnt;
  logic        eval_vld;
  logic        hit;
  logic [IDX_W-1:0] hit_idx;
  logic        free_found;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] fail_cnt;
  logic        temp_found;
  logic [BYTE_W-1:0] temp_val;
  logic [IDX_W-1:0] eval_k;

  logic        out_valid;
  status_t     out_status;
  logic [COUNT_W-1:0] out_failing;
  logic        out_healthy;
  logic        out_temp_found;
  logic [BYTE_W-1:0] out_temp;

  logic        accept;
  logic        issue_more;
  logic        advance;
  logic        do_write;
  attr_entry_t rd_entry;
  logic        rd_used;
  attr_entry_t ev_entry;
  logic        ev_used;
  eval_res_t   ev;
  logic [CNT_W-1:0] fail_next;
  logic [SUM_W-1:0] fail_wide;
  status_t     status_next;
  logic        temp_found_next;
  logic [BYTE_W-1:0] temp_next;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign issue_more = (state == S_SCAN) && (iss_cnt != CNT_W'(ENTRIES));
  assign advance    = (state == S_WRITE) && (!out_valid || out_ch.ready);
  assign do_write   = (req.id != '0) && (hit || free_found);

  sat_store #(.ENTRIES(ENTRIES)) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (issue_more),
    .rd_addr  (iss_cnt[IDX_W-1:0]),
    .rd_entry (rd_entry),
    .rd_used  (rd_used),
    .wr_en    (advance && do_write),
    .wr_addr  (hit ? hit_idx : free_idx),
    .wr_entry (req)
  );

  assign ev_entry = (state == S_SCAN) ? rd_entry : req;
  assign ev_used  = (state == S_SCAN) ? rd_used : 1'b1;

  sat_eval u_eval (
    .scan   (state == S_SCAN),
    .used   (ev_used),
    .entry  (ev_entry),
    .req_id (req.id),
    .res    (ev)
  );

  // fold in the new entry once the scan has settled
  always_comb begin
    fail_next       = fail_cnt + CNT_W'(do_write && ev.fail);
    fail_wide       = SUM_W'(fail_next);
    temp_found_next = temp_found;
    temp_next       = temp_val;
    if (do_write && ev.temp) begin
      temp_found_next = 1'b1;
      temp_next       = req.raw[BYTE_W-1:0];
    end
    priority if (req.id == '0) begin
      status_next = STATUS_INVALID;
    end else if (hit || free_found) begin
      status_next = STATUS_STORED;
    end else begin
      status_next = STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      eval_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      eval_vld <= issue_more;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issue_more && !eval_vld) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (advance) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.id        <= in_ch.attr_id;
      req.value     <= in_ch.attr_value;
      req.worst     <= in_ch.attr_worst;
      req.threshold <= in_ch.attr_threshold;
      req.raw       <= in_ch.attr_raw;
      iss_cnt       <= '0;
      hit           <= 1'b0;
      free_found    <= 1'b0;
      fail_cnt      <= '0;
      temp_found    <= 1'b0;
      temp_val      <= '0;
    end
    if (issue_more) begin
      iss_cnt <= iss_cnt + CNT_W'(1);
      eval_k  <= iss_cnt[IDX_W-1:0];
    end
    if (state == S_SCAN && eval_vld) begin
      if (ev.match) begin
        hit     <= 1'b1;
        hit_idx <= eval_k;
      end
      if (ev.free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= eval_k;
      end
      if (ev.fail) begin
        fail_cnt <= fail_cnt + CNT_W'(1);
      end
      if (ev.temp) begin
        temp_found <= 1'b1;
        temp_val   <= rd_entry.raw[BYTE_W-1:0];
      end
    end
    if (advance) begin
      out_status     <= status_next;
      out_failing    <= (fail_wide > SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                        : fail_wide[COUNT_W-1:0];
      out_healthy    <= (fail_next == '0);
      out_temp_found <= temp_found_next;
      out_temp       <= temp_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.failing_count = out_failing;
  assign out_ch.healthy       = out_healthy;
  assign out_ch.temp_found    = out_temp_found;
  assign out_ch.temperature   = out_temp;

endmodule

/* tb/tb_smart_attribute_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_smart_attribute_table
// Self-checking bench for the attribute table. Reports go in over the
// valid-ready input channel and every result is checked against a shadow
// table kept in the bench. The run covers the invalid id, store, update in
// place, threshold edges, temperature absent and present, a random growth
// phase, a full table, the failing-count extremes and a long random phase.
// Both sides idle at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_smart_attribute_table;
  import sat_pkg::*;

  localparam int TBL_ENTRIES = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTED = 10;

  typedef struct {
    status_t              status;
    logic [COUNT_W-1:0]   failing_count;
    logic                 healthy;
    logic                 temp_found;
    logic [BYTE_W-1:0]    temperature;
  } table_result_t;

  logic clk = 1'b0;
  logic rst;
  logic calm = 1'b0;

  sat_in_if  in_ch();
  sat_out_if out_ch();

  smart_attribute_table #(.ENTRIES(TBL_ENTRIES)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic              shadow_used      [TBL_ENTRIES];
  logic [ID_W-1:0]   shadow_id        [TBL_ENTRIES];
  logic [BYTE_W-1:0] shadow_value     [TBL_ENTRIES];
  logic [BYTE_W-1:0] shadow_worst     [TBL_ENTRIES];
  logic [BYTE_W-1:0] shadow_threshold [TBL_ENTRIES];
  logic [RAW_W-1:0]  shadow_raw       [TBL_ENTRIES];
  int                shadow_fill = 0;

  table_result_t pending_results[$];

  int cycle_count = 0;
  int reports_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int status_seen[3] = '{0, 0, 0};
  int max_failing_seen = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb_smart_attribute_table: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 18);
  end

  function automatic table_result_t apply_report(attr_entry_t rpt);
    table_result_t res;
    int slot;
    int fails;
    slot = -1;
    fails = 0;
    res.temp_found = 1'b0;
    res.temperature = '0;
    if (rpt.id == '0) begin
      res.status = STATUS_INVALID;
    end else begin
      for (int k = 0; k < TBL_ENTRIES; k++)
        if (slot < 0 && shadow_used[k] && shadow_id[k] == rpt.id) slot = k;
      if (slot < 0) begin
        for (int k = 0; k < TBL_ENTRIES; k++)
          if (slot < 0 && !shadow_used[k]) slot = k;
        if (slot >= 0) shadow_fill++;
      end
      if (slot < 0) begin
        res.status = STATUS_FULL;
      end else begin
        res.status = STATUS_STORED;
        shadow_used[slot]      = 1'b1;
        shadow_id[slot]        = rpt.id;
        shadow_value[slot]     = rpt.value;
        shadow_worst[slot]     = rpt.worst;
        shadow_threshold[slot] = rpt.threshold;
        shadow_raw[slot]       = rpt.raw;
      end
    end
    for (int k = 0; k < TBL_ENTRIES; k++) begin
      if (shadow_used[k]) begin
        if (shadow_threshold[k] != '0 && shadow_value[k] <= shadow_threshold[k]) fails++;
        if (!res.temp_found && shadow_id[k] == TEMP_ID) begin
          res.temp_found = 1'b1;
          res.temperature = shadow_raw[k][BYTE_W-1:0];
        end
      end
    end
    res.failing_count = (fails > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(fails);
    res.healthy = (fails == 0);
    return res;
  endfunction

  function automatic logic id_present(logic [ID_W-1:0] id);
    for (int k = 0; k < TBL_ENTRIES; k++)
      if (shadow_used[k] && shadow_id[k] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic attr_entry_t rand_report(logic [ID_W-1:0] id);
    attr_entry_t rpt;
    rpt.id = id;
    rpt.worst = rand_byte();
    rpt.raw = rand_raw();
    rpt.threshold = ($urandom_range(99) < 20) ? '0 : rand_byte();
    case ($urandom_range(3))
      0: rpt.value = rpt.threshold;
      1: rpt.value = rpt.threshold + BYTE_W'($urandom_range(2)) - 8'd1;
      default: rpt.value = rand_byte();
    endcase
    return rpt;
  endfunction

  function automatic attr_entry_t mk_report(logic [ID_W-1:0] id, logic [BYTE_W-1:0] value,
                                            logic [BYTE_W-1:0] threshold,
                                            logic [RAW_W-1:0] raw);
    attr_entry_t rpt;
    rpt.id = id;
    rpt.value = value;
    rpt.worst = value;
    rpt.threshold = threshold;
    rpt.raw = raw;
    return rpt;
  endfunction

  function automatic logic [ID_W-1:0] pick_stored_id();
    return shadow_id[$urandom_range(shadow_fill - 1)];
  endfunction

  // Leaves valid high after acceptance; the next call lowers or reuses it.
  task automatic send_report(attr_entry_t rpt);
    if (!calm && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_ch.valid          <= 1'b1;
    in_ch.attr_id        <= rpt.id;
    in_ch.attr_value     <= rpt.value;
    in_ch.attr_worst     <= rpt.worst;
    in_ch.attr_threshold <= rpt.threshold;
    in_ch.attr_raw       <= rpt.raw;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_report(rpt));
    reports_sent++;
  endtask

  task automatic check_result();
    table_result_t exp_res;
    results_seen++;
    if (out_ch.status <= 2'd2) status_seen[out_ch.status]++;
    if (int'(out_ch.failing_count) > max_failing_seen)
      max_failing_seen = int'(out_ch.failing_count);
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("unexpected result at cycle %0d: status %0d", cycle_count, out_ch.status);
    end else begin
      exp_res = pending_results.pop_front();
      if (out_ch.status !== exp_res.status || out_ch.failing_count !== exp_res.failing_count ||
          out_ch.healthy !== exp_res.healthy || out_ch.temp_found !== exp_res.temp_found ||
          out_ch.temperature !== exp_res.temperature) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
          $display("mismatch on result %0d: exp st %0d fail %0d ok %0b tf %0b temp %0d",
                   results_seen, exp_res.status, exp_res.failing_count, exp_res.healthy,
                   exp_res.temp_found, exp_res.temperature);
          $display("  got st %0d fail %0d ok %0b tf %0b temp %0d", out_ch.status,
                   out_ch.failing_count, out_ch.healthy, out_ch.temp_found,
                   out_ch.temperature);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) check_result();
  end

  task automatic test_empty_table();
    send_report(mk_report(8'd0, 8'd0, 8'd0, '0));
    send_report(mk_report(8'd1, 8'd0, 8'd0, '0));
    send_report(mk_report(8'd255, 8'd255, 8'd255, '1));
  endtask

  task automatic test_threshold_edges();
    send_report(mk_report(8'd5, 8'd10, 8'd11, 48'd77));
    send_report(mk_report(8'd5, 8'd12, 8'd11, 48'd78));
    send_report(mk_report(8'd5, 8'd11, 8'd11, 48'd79));
    send_report(mk_report(8'd0, 8'd255, 8'd1, '1));
    send_report(mk_report(8'd2, 8'd0, 8'd1, 48'd1));
  endtask

  task automatic test_temperature();
    send_report(mk_report(8'd193, 8'd100, 8'd0, '1));
    send_report(mk_report(8'd195, 8'd100, 8'd50, '1));
    send_report(mk_report(TEMP_ID, 8'd100, 8'd0, '0));
    send_report(mk_report(TEMP_ID, 8'd100, 8'd0, '1));
    send_report(mk_report(TEMP_ID, 8'd90, 8'd40, 48'h1234_5678_9A42));
  endtask

  task automatic test_update_in_place();
    send_report(mk_report(8'd1, 8'd255, 8'd255, '1));
    send_report(mk_report(8'd128, 8'd1, 8'd0, 48'h8000_0000_0000));
    send_report(mk_report(8'd255, 8'd0, 8'd0, '0));
  endtask

  // Mostly updates; new ids arrive slowly so the table fills gradually.
  task automatic test_random_growth(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) send_report(rand_report(8'd0));
      else if (pick < 16) send_report(rand_report(ID_W'($urandom_range(255, 1))));
      else send_report(rand_report(pick_stored_id()));
    end
  endtask

  task automatic test_fill_table();
    logic [ID_W-1:0] id;
    while (shadow_fill < TBL_ENTRIES) begin
      do id = ID_W'($urandom_range(255, 1)); while (id_present(id));
      send_report(rand_report(id));
    end
    do id = ID_W'($urandom_range(255, 1)); while (id_present(id));
    send_report(rand_report(id));
    send_report(rand_report(8'd0));
  endtask

  task automatic test_failing_extremes();
    for (int k = 0; k < TBL_ENTRIES; k++)
      send_report(mk_report(shadow_id[k], 8'd0, 8'd255, rand_raw()));
    for (int k = 0; k < TBL_ENTRIES; k++)
      send_report(mk_report(shadow_id[k], rand_byte(), 8'd0, rand_raw()));
  endtask

  task automatic test_random_full(int n, int calm_items);
    int pick;
    calm = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i == calm_items) calm = 1'b0;
      pick = $urandom_range(99);
      if (pick < 10) send_report(rand_report(8'd0));
      else if (pick < 50) send_report(rand_report(ID_W'($urandom_range(255, 1))));
      else send_report(rand_report(pick_stored_id()));
    end
  endtask

  initial begin
    for (int k = 0; k < TBL_ENTRIES; k++) shadow_used[k] = 1'b0;
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.attr_id        <= '0;
    in_ch.attr_value     <= '0;
    in_ch.attr_worst     <= '0;
    in_ch.attr_threshold <= '0;
    in_ch.attr_raw       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_threshold_edges();
    test_temperature();
    test_update_in_place();
    test_random_growth(400);
    test_fill_table();
    test_failing_extremes();
    test_random_full(600, 150);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d reports, %0d results: stored %0d, invalid %0d, full %0d",
             reports_sent, results_seen, status_seen[STATUS_STORED],
             status_seen[STATUS_INVALID], status_seen[STATUS_FULL]);
    $display("failing count reached %0d, %0d mismatches in %0d cycles", max_failing_seen,
             mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("tb_smart_attribute_table: PASS");
    end else begin
      $display("tb_smart_attribute_table: FAIL");
    end
    $finish;
  end

endmodule
